>>> hdl/brmt_pkg.sv
// Package for the byte register multiplier timer: operation codes, register offsets,
// command and response structs, and byte helpers.
// No dependencies; both RTL modules import it.
package brmt_pkg;

    // Operation carried in tuser of the input stream. Code 3 is unused and does nothing.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    localparam int unsigned OFF_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;

    localparam logic [OFF_W-1:0] OFF_STATUS = 4'd0;
    localparam logic [OFF_W-1:0] OFF_A0     = 4'd1;
    localparam logic [OFF_W-1:0] OFF_A3     = 4'd4;
    localparam logic [OFF_W-1:0] OFF_B0     = 4'd5;
    localparam logic [OFF_W-1:0] OFF_B3     = 4'd8;
    localparam logic [OFF_W-1:0] OFF_P0     = 4'd9;
    localparam logic [OFF_W-1:0] OFF_P3     = 4'd12;

    localparam logic [BYTE_W-1:0] STATUS_TICK = 8'h80;
    localparam logic [WORD_W-1:0] LOW_HALF    = 32'h0000_ffff;

    typedef struct packed {
        t_op               op;
        logic [OFF_W-1:0]  offset;
        logic [BYTE_W-1:0] wdata;
    } t_cmd;

    typedef struct packed {
        logic              irq;
        logic [BYTE_W-1:0] rdata;
    } t_rsp;

    function automatic logic [BYTE_W-1:0] get_byte(input logic [WORD_W-1:0] word,
                                                   input logic [1:0]        idx);
        return word[idx*BYTE_W +: BYTE_W];
    endfunction

    function automatic logic [WORD_W-1:0] set_byte(input logic [WORD_W-1:0] word,
                                                   input logic [1:0]        idx,
                                                   input logic [BYTE_W-1:0] val);
        logic [WORD_W-1:0] res;
        res = word;
        res[idx*BYTE_W +: BYTE_W] = val;
        return res;
    endfunction

    // Writing byte 0 or 1 of an operand also clears its upper half.
    function automatic logic [WORD_W-1:0] write_operand(input logic [WORD_W-1:0] word,
                                                        input logic [1:0]        idx,
                                                        input logic [BYTE_W-1:0] val);
        logic [WORD_W-1:0] res;
        res = set_byte(word, idx, val);
        if (!idx[1]) begin
            res = res & LOW_HALF;
        end
        return res;
    endfunction

endpackage

>>> hdl/byte_register_multiplier_timer.sv
// Top level of the byte register multiplier timer: input beat register, register file
// core and result register on stream ports. Depends on brmt_pkg and brmt_core.
// A beat is held in the input register, passes through the core and is captured in the
// result register, which drives m_axis_tvalid until the result is taken.
// Throughput: one beat per cycle while m_axis_tready does not stall the result register;
// the single 32x32 multiply sits between the input register and the result register.
// Reset: i_rst_n is synchronous and active low; it clears the operands, the product, the
// status byte and both valid flags, which empties both pipeline stages.
module byte_register_multiplier_timer import brmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream: one bus read, write or timer tick per beat.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] reg_offset, [11:4] write_byte, [15:12] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // Output stream: one result per input beat.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] read_byte, [8] irq_request, [15:9] zero
);

    // Input beat register.
    logic r_in_valid;
    t_cmd r_in_cmd;
    // Result register.
    logic r_out_valid;
    t_rsp r_out_rsp;

    logic w_out_ready;
    logic w_advance;
    t_rsp w_rsp;

    // The result register can load when it is empty or being drained this cycle.
    // The input register then advances into the core, which updates its state in
    // the same cycle that the result is captured.
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_ready;
    assign s_axis_tready = !r_in_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd.op     <= t_op'(s_axis_tuser);
            r_in_cmd.offset <= s_axis_tdata[3:0];
            r_in_cmd.wdata  <= s_axis_tdata[11:4];
        end
    end

    brmt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_cmd   (r_in_cmd),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_rsp <= w_rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_rsp.irq, r_out_rsp.rdata};

endmodule

>>> hdl/brmt_core.sv
// Register file of the byte register multiplier timer: operands, product, status,
// the 32x32 multiplier and the byte read and write decode. Depends on brmt_pkg.
module brmt_core import brmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_cmd i_cmd,
    output t_rsp o_rsp
);

    logic [WORD_W-1:0] r_a, r_b, r_p;
    logic [BYTE_W-1:0] r_status;
    logic [WORD_W-1:0] n_a, n_b, n_p;
    logic [BYTE_W-1:0] n_status;
    logic [WORD_W-1:0] w_prod;
    logic [1:0]        w_idx_a, w_idx_b, w_idx_p;

    // Low 32 bits of A*B; the product wraps.
    assign w_prod  = r_a * r_b;
    assign w_idx_a = 2'(i_cmd.offset - OFF_A0);
    assign w_idx_b = 2'(i_cmd.offset - OFF_B0);
    assign w_idx_p = 2'(i_cmd.offset - OFF_P0);

    always_comb begin
        n_a          = r_a;
        n_b          = r_b;
        n_p          = r_p;
        n_status     = r_status;
        o_rsp.rdata  = '0;
        o_rsp.irq    = 1'b0;
        case (i_cmd.op)
            OP_READ: begin
                unique case (i_cmd.offset) inside
                    OFF_STATUS:       o_rsp.rdata = r_status;
                    [OFF_A0:OFF_A3]:  o_rsp.rdata = get_byte(r_a, w_idx_a);
                    [OFF_B0:OFF_B3]:  o_rsp.rdata = get_byte(r_b, w_idx_b);
                    [OFF_P0:OFF_P3]: begin
                        // Even product bytes reload the product before the read.
                        if (!w_idx_p[0]) begin
                            n_p         = w_prod;
                            o_rsp.rdata = get_byte(w_prod, w_idx_p);
                        end else begin
                            o_rsp.rdata = get_byte(r_p, w_idx_p);
                        end
                    end
                    default:          o_rsp.rdata = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_cmd.offset) inside
                    OFF_STATUS:       n_status = i_cmd.wdata;
                    [OFF_A0:OFF_A3]:  n_a = write_operand(r_a, w_idx_a, i_cmd.wdata);
                    [OFF_B0:OFF_B3]:  n_b = write_operand(r_b, w_idx_b, i_cmd.wdata);
                    [OFF_P0:OFF_P3]:  n_p = set_byte(r_p, w_idx_p, i_cmd.wdata);
                    default:          n_status = r_status;
                endcase
            end
            OP_TICK: begin
                n_status  = STATUS_TICK;
                o_rsp.irq = 1'b1;
            end
            default: o_rsp.irq = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a      <= '0;
            r_b      <= '0;
            r_p      <= '0;
            r_status <= '0;
        end else if (i_fire) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_p      <= n_p;
            r_status <= n_status;
        end
    end

    a_tick_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_cmd.op == OP_TICK |=> r_status == STATUS_TICK)
        else $error("tick did not set status");

    a_irq_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.irq |-> i_cmd.op == OP_TICK)
        else $error("irq raised by a non-tick item");

    a_prod_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_cmd.op == OP_READ && (i_cmd.offset == OFF_P0 || i_cmd.offset == OFF_P0 + 4'd2)
        |=> r_p == $past(w_prod))
        else $error("product not reloaded on even byte read");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_a) && $stable(r_b) && $stable(r_p) && $stable(r_status))
        else $error("state changed without an item");

endmodule
